FILE: hdl/iira_pkg.sv
// package: request and response types, mode and status codes for the insert/remove array
`default_nettype none

package iira_pkg;

    // fixed widths of the request and response fields
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned STATUS_W = 2;

    // request modes, code 7 is unused and does nothing
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 3'd0,
        MODE_PREPEND   = 3'd1,
        MODE_INSERT    = 3'd2,
        MODE_REM_LAST  = 3'd3,
        MODE_REM_FIRST = 3'd4,
        MODE_REM_AT    = 3'd5,
        MODE_READ      = 3'd6
    } t_mode;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // one request
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    // one response
    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [COUNT_W-1:0]        element_count;
        logic [STATUS_W-1:0]       status;
    } t_rsp;

    // per-cycle shift command broadcast to every cell
    typedef struct packed {
        logic open_gap;
        logic close_gap;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hdl/iira_cell.sv
// one storage cell of the element chain, shifts with its neighbors on insert and remove
`default_nettype none

module iira_cell #(
    parameter int unsigned INDEX      = 0,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned IDX_W      = 6
) (
    input  wire                       i_clk,
    input  iira_pkg::t_cell_ctl       i_ctl,
    input  wire  [IDX_W-1:0]          i_pos,
    input  wire  [DATA_WIDTH-1:0]     i_new,
    input  wire  [DATA_WIDTH-1:0]     i_left,
    input  wire  [DATA_WIDTH-1:0]     i_right,
    output logic [DATA_WIDTH-1:0]     o_data,
    output logic [DATA_WIDTH-1:0]     o_hit_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_at;
    logic                  w_above;

    // position compare against this cell's slot
    assign w_at    = (i_pos == MY_IDX);
    assign w_above = (MY_IDX > i_pos);

    // next value: take the left neighbor, the new word, the right neighbor, or hold
    always_comb begin
        n_data = r_data;
        if (i_ctl.open_gap) begin
            if (w_above) begin
                n_data = i_left;
            end else if (w_at) begin
                n_data = i_new;
            end
        end else if (i_ctl.close_gap) begin
            if (w_above || w_at) begin
                n_data = i_right;
            end
        end
    end

    // element storage
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    // only the addressed cell drives the shared read bus
    assign o_hit_data = w_at ? r_data : '0;

endmodule

`default_nettype wire

FILE: hdl/indexed_insert_remove_array.sv
// top level: ordered word list with indexed insert, remove and read over a chain of cells
//
// Usage:
//   Requests enter on i_req with i_req_valid/o_req_ready; each carries a mode
//   (append, prepend, insert at position, remove last, remove first, remove at
//   position, read at position), a position and a word. Every request returns
//   exactly one response on o_rsp with o_rsp_valid/i_rsp_ready: the removed or
//   read word (zero otherwise), the element count after the request and a status.
//   The response is registered and valid in the cycle after acceptance.
//   Throughput: one request per cycle unless the receiver stalls; every cell compares
//   the position with its own slot and shifts in parallel, so the whole chain moves at once.
//   A request is taken whenever the response register is empty or is being
//   drained in the same cycle; when the receiver stalls, the response holds and
//   o_req_ready drops until it is taken.
//   Reset (synchronous, active low) empties the list and the response register.
//   Stored words have no reset; only slots below the count are ever read.
`default_nettype none

module indexed_insert_remove_array #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_req_valid,
    output logic           o_req_ready,
    input  iira_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  wire            i_rsp_ready,
    output iira_pkg::t_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CMP_W = (CNT_W > iira_pkg::COUNT_W) ? CNT_W : iira_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_rsp_valid;
    iira_pkg::t_rsp        r_rsp;
    iira_pkg::t_rsp        n_rsp;

    logic                  w_accept;
    logic [CMP_W-1:0]      w_cnt_x;
    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_tgt;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_open;
    logic                  w_close;
    logic                  w_take;
    iira_pkg::t_status     w_status;
    iira_pkg::t_cell_ctl   w_ctl;
    logic [IDX_W-1:0]      w_cell_pos;
    logic [DATA_WIDTH-1:0] w_new;
    logic [DATA_WIDTH-1:0] w_rd;
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_hit  [CAPACITY];

    // handshake: a new request enters when the response slot is free or draining
    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign w_accept    = i_req_valid && o_req_ready;

    // operand widening for the range and full checks
    assign w_cnt_x = CMP_W'(r_count);
    assign w_pos_x = CMP_W'(i_req.position);
    assign w_full  = (r_count == CNT_FULL);
    assign w_empty = (r_count == '0);
    assign w_new   = DATA_WIDTH'($unsigned(i_req.value));

    // mode decode and status checks
    always_comb begin
        w_status = iira_pkg::ST_OK;
        w_open   = 1'b0;
        w_close  = 1'b0;
        w_take   = 1'b0;
        w_tgt    = '0;
        unique case (iira_pkg::t_mode'(i_req.mode))
            iira_pkg::MODE_APPEND: begin
                w_tgt = w_cnt_x;
                if (w_full) begin
                    w_status = iira_pkg::ST_FULL;
                end else begin
                    w_open = 1'b1;
                end
            end
            iira_pkg::MODE_PREPEND: begin
                if (w_full) begin
                    w_status = iira_pkg::ST_FULL;
                end else begin
                    w_open = 1'b1;
                end
            end
            iira_pkg::MODE_INSERT: begin
                w_tgt = w_pos_x;
                if (w_pos_x > w_cnt_x) begin
                    w_status = iira_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = iira_pkg::ST_FULL;
                end else begin
                    w_open = 1'b1;
                end
            end
            iira_pkg::MODE_REM_LAST: begin
                w_tgt = w_cnt_x - CMP_W'(1);
                if (w_empty) begin
                    w_status = iira_pkg::ST_EMPTY;
                end else begin
                    w_close = 1'b1;
                    w_take  = 1'b1;
                end
            end
            iira_pkg::MODE_REM_FIRST: begin
                if (w_empty) begin
                    w_status = iira_pkg::ST_EMPTY;
                end else begin
                    w_close = 1'b1;
                    w_take  = 1'b1;
                end
            end
            iira_pkg::MODE_REM_AT: begin
                w_tgt = w_pos_x;
                if (w_empty) begin
                    w_status = iira_pkg::ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = iira_pkg::ST_RANGE;
                end else begin
                    w_close = 1'b1;
                    w_take  = 1'b1;
                end
            end
            iira_pkg::MODE_READ: begin
                w_tgt = w_pos_x;
                if (w_empty) begin
                    w_status = iira_pkg::ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = iira_pkg::ST_RANGE;
                end else begin
                    w_take = 1'b1;
                end
            end
            default: begin
                w_status = iira_pkg::ST_OK;
            end
        endcase
    end

    // shift command to the chain, only on an accepted request
    assign w_ctl.open_gap  = w_accept && w_open;
    assign w_ctl.close_gap = w_accept && w_close;
    assign w_cell_pos      = w_tgt[IDX_W-1:0];

    // the chain of cells
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (k == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[k-1];
            end
            if (k == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[k+1];
            end
            iira_cell #(
                .INDEX      (k),
                .DATA_WIDTH (DATA_WIDTH),
                .IDX_W      (IDX_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_pos      (w_cell_pos),
                .i_new      (w_new),
                .i_left     (w_left),
                .i_right    (w_right),
                .o_data     (w_data[k]),
                .o_hit_data (w_hit[k])
            );
        end
    endgenerate

    // read bus: or of the per-cell hit words, only the addressed cell is nonzero
    always_comb begin
        w_rd = '0;
        for (int unsigned j = 0; j < CAPACITY; j++) begin
            w_rd = w_rd | w_hit[j];
        end
    end

    // next count
    always_comb begin
        n_count = r_count;
        if (w_ctl.open_gap) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.close_gap) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // response word for this request
    always_comb begin
        n_rsp.result_value  = w_take ? 32'($signed(w_rd)) : '0;
        n_rsp.element_count = iira_pkg::COUNT_W'(n_count);
        n_rsp.status        = w_status;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // response payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

FILE: bench/indexed_insert_remove_array_tb.sv
// testbench: randomized request stream with a built-in list predictor for the insert/remove array
`timescale 1ns / 100ps

module indexed_insert_remove_array_tb;

    localparam int unsigned CAP          = 64;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned LONG_HOLD    = 60;
    localparam logic [iira_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef enum {PH_GROW, PH_MIXED, PH_SHRINK} t_phase;

    // one queued request with its lead-in gap
    typedef struct {
        iira_pkg::t_req req;
        int unsigned    gap;
        bit             drain;
    } t_stim;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    iira_pkg::t_req req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b1;
    iira_pkg::t_rsp rsp;

    // predictor state
    logic [iira_pkg::VALUE_W-1:0] stored_words [CAP];
    int unsigned                  word_count = 0;

    t_stim          pending_reqs [$];
    iira_pkg::t_rsp responses_due [$];
    bit             req_taken = 1'b0;
    int unsigned    gap_cnt = 0;
    int unsigned    hold_left = 0;
    bit             long_hold_done = 1'b0;
    int unsigned    accepted_cnt = 0;
    int unsigned    cycle_cnt = 0;
    int unsigned    err_cnt = 0;
    int unsigned    status_seen [4] = '{0, 0, 0, 0};
    int unsigned    longest_list = 0;

    indexed_insert_remove_array u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    // clock and reset
    always #1 clk = ~clk;

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // open a slot at p, shifting later words up
    function automatic void open_slot(int unsigned p, logic [iira_pkg::VALUE_W-1:0] v);
        int unsigned k;
        for (k = word_count; k > p; k--)
            stored_words[k] = stored_words[k-1];
        stored_words[p] = v;
        word_count++;
    endfunction

    // take the word at p out and close the gap
    function automatic logic [iira_pkg::VALUE_W-1:0] close_slot(int unsigned p);
        logic [iira_pkg::VALUE_W-1:0] old;
        int unsigned k;
        old = stored_words[p];
        for (k = p; k + 1 < word_count; k++)
            stored_words[k] = stored_words[k+1];
        word_count--;
        return old;
    endfunction

    // expected response for one request, updating the list
    function automatic iira_pkg::t_rsp apply_request(iira_pkg::t_req r);
        iira_pkg::t_rsp o;
        int unsigned p;
        p = 32'(r.position);
        o = '0;
        o.status = iira_pkg::ST_OK;
        case (r.mode)
            iira_pkg::MODE_APPEND, iira_pkg::MODE_PREPEND, iira_pkg::MODE_INSERT: begin
                if (r.mode == iira_pkg::MODE_INSERT && p > word_count)
                    o.status = iira_pkg::ST_RANGE;
                else if (word_count == CAP)
                    o.status = iira_pkg::ST_FULL;
                else if (r.mode == iira_pkg::MODE_APPEND)
                    open_slot(word_count, r.value);
                else if (r.mode == iira_pkg::MODE_PREPEND)
                    open_slot(0, r.value);
                else
                    open_slot(p, r.value);
            end
            iira_pkg::MODE_REM_LAST, iira_pkg::MODE_REM_FIRST, iira_pkg::MODE_REM_AT,
            iira_pkg::MODE_READ: begin
                if (word_count == 0)
                    o.status = iira_pkg::ST_EMPTY;
                else if (r.mode == iira_pkg::MODE_REM_LAST)
                    o.result_value = close_slot(word_count - 1);
                else if (r.mode == iira_pkg::MODE_REM_FIRST)
                    o.result_value = close_slot(0);
                else if (p >= word_count)
                    o.status = iira_pkg::ST_RANGE;
                else if (r.mode == iira_pkg::MODE_REM_AT)
                    o.result_value = close_slot(p);
                else
                    o.result_value = stored_words[p];
            end
            default: ;
        endcase
        o.element_count = word_count[iira_pkg::COUNT_W-1:0];
        return o;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mode mix per phase kind
    function automatic logic [iira_pkg::MODE_W-1:0] pick_mode(t_phase kind);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ((kind == PH_GROW && roll < 90) || (kind == PH_SHRINK && roll >= 85))
            return iira_pkg::MODE_W'($urandom_range(iira_pkg::MODE_APPEND,
                                                    iira_pkg::MODE_INSERT));
        if (kind != PH_MIXED)
            return iira_pkg::MODE_W'($urandom_range(iira_pkg::MODE_REM_LAST, MODE_UNUSED));
        return iira_pkg::MODE_W'($urandom_range(iira_pkg::MODE_APPEND, MODE_UNUSED));
    endfunction

    // queue one request, tracking the list so positions can follow it
    function automatic void add_item(logic [iira_pkg::MODE_W-1:0] mode, int unsigned pos,
                                     logic [iira_pkg::VALUE_W-1:0] value, int unsigned gap,
                                     bit drain);
        t_stim s;
        iira_pkg::t_rsp r;
        s.req.mode     = mode;
        s.req.position = pos[iira_pkg::POS_W-1:0];
        s.req.value    = value;
        s.gap          = gap;
        s.drain        = drain;
        r = apply_request(s.req);
        status_seen[r.status]++;
        if (word_count > longest_list)
            longest_list = word_count;
        pending_reqs.push_back(s);
    endfunction

    // stimulus, then wait for the end
    initial begin
        int unsigned phase;
        int unsigned plen;
        int unsigned k;
        int unsigned made;
        int unsigned pos;
        int unsigned gap;
        logic [iira_pkg::VALUE_W-1:0] value;
        t_phase kind;

        // directed: empty list, range edges, value extremes, unused mode
        add_item(iira_pkg::MODE_READ,      0,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_LAST,  0,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_FIRST, 0,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_AT,    63, 32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_INSERT,    1,  32'd5,        0, 1'b0);
        add_item(MODE_UNUSED,              0,  32'hFFFFFFFF, 0, 1'b0);
        add_item(iira_pkg::MODE_APPEND,    0,  32'h7FFFFFFF, 0, 1'b0);
        add_item(iira_pkg::MODE_PREPEND,   63, 32'h80000000, 0, 1'b0);
        add_item(iira_pkg::MODE_INSERT,    1,  32'hFFFFFFFF, 0, 1'b0);
        add_item(iira_pkg::MODE_INSERT,    3,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_INSERT,    0,  32'h55555555, 0, 1'b0);
        add_item(iira_pkg::MODE_INSERT,    6,  32'd1,        0, 1'b0);
        add_item(iira_pkg::MODE_READ,      0,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_READ,      4,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_READ,      5,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_READ,      63, 32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_AT,    2,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_FIRST, 0,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_LAST,  0,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_AT,    2,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_AT,    1,  32'd0,        0, 1'b0);
        add_item(MODE_UNUSED,              42, 32'd7,        0, 1'b0);
        add_item(iira_pkg::MODE_REM_AT,    0,  32'd0,        0, 1'b0);
        add_item(iira_pkg::MODE_INSERT,    0,  32'hAAAAAAAA, 0, 1'b0);
        add_item(iira_pkg::MODE_READ,      0,  32'd0,        0, 1'b0);

        // random phases: grow to full, mix, shrink to empty, mix
        phase = 0;
        made = 0;
        while (made < RANDOM_ITEMS) begin
            case (phase % 4)
                0:       kind = PH_GROW;
                2:       kind = PH_SHRINK;
                default: kind = PH_MIXED;
            endcase
            plen = (phase == 0) ? 100 : $urandom_range(20, 90);
            for (k = 0; k < plen; k++) begin
                if ($urandom_range(0, 3) != 0)
                    pos = $urandom_range(0, (word_count > 63) ? 63 : word_count);
                else
                    pos = $urandom_range(0, 63);
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       value = 32'h7FFFFFFF;
                        1:       value = 32'h80000000;
                        2:       value = 32'd0;
                        default: value = 32'hFFFFFFFF;
                    endcase
                end else begin
                    value = $urandom;
                end
                // every third phase the sender runs back to back
                if (phase % 3 == 1 || $urandom_range(0, 9) >= 4)
                    gap = 0;
                else
                    gap = pick_gap();
                add_item(pick_mode(kind), pos, value, gap, k == 0);
            end
            made += plen;
            phase++;
        end

        // generation walked the predictor; start it over for the checks
        word_count = 0;

        @(posedge rst_n);
        while (pending_reqs.size() != 0 || req_valid || responses_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d requests checked, list reached %0d of %0d words",
                 accepted_cnt, longest_list, CAP);
        $display("status mix: ok %0d, full %0d, out of range %0d, empty %0d",
                 status_seen[iira_pkg::ST_OK], status_seen[iira_pkg::ST_FULL],
                 status_seen[iira_pkg::ST_RANGE], status_seen[iira_pkg::ST_EMPTY]);
        if (err_cnt == 0 && responses_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // request driver
    always @(negedge clk) begin
        if (rst_n && (!req_valid || req_taken)) begin
            if (pending_reqs.size() == 0) begin
                req_valid <= 1'b0;
            end else if (gap_cnt < pending_reqs[0].gap) begin
                req_valid <= 1'b0;
                gap_cnt <= gap_cnt + 1;
            end else if (pending_reqs[0].drain && responses_due.size() != 0) begin
                // pause until every response is back
                req_valid <= 1'b0;
            end else begin
                req <= pending_reqs[0].req;
                req_valid <= 1'b1;
                gap_cnt <= 0;
                void'(pending_reqs.pop_front());
            end
        end
    end

    // response receiver: quiet stretches, random stalls and one long hold-off
    always @(negedge clk) begin
        if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && accepted_cnt >= 200) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
        end else if ((cycle_cnt / 100) % 3 == 0) begin
            rsp_ready <= 1'b1;
        end else if ($urandom_range(0, 9) < 2) begin
            hold_left <= pick_gap() - 1;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    // monitor: check responses, predict accepted requests
    always @(posedge clk) begin : monitor
        iira_pkg::t_rsp want;
        req_taken = 1'b0;
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (responses_due.size() == 0) begin
                    err_cnt++;
                    $error("response with no request outstanding");
                end else begin
                    want = responses_due.pop_front();
                    if (rsp.result_value !== want.result_value) begin
                        err_cnt++;
                        $error("result_value expected %0d got %0d",
                               want.result_value, rsp.result_value);
                    end
                    if (rsp.element_count !== want.element_count) begin
                        err_cnt++;
                        $error("element_count expected %0d got %0d",
                               want.element_count, rsp.element_count);
                    end
                    if (rsp.status !== want.status) begin
                        err_cnt++;
                        $error("status expected %0d got %0d", want.status, rsp.status);
                    end
                end
            end
            if (req_valid && req_ready) begin
                responses_due.push_back(apply_request(req));
                req_taken = 1'b1;
                accepted_cnt++;
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
